### hdl/euler_flux_2d_defines.svh
// Assertion macros used by the checker file.
`ifndef EULER_FLUX_2D_DEFINES_SVH
`define EULER_FLUX_2D_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EFX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/efx_pkg.sv
package efx_pkg;

  localparam int unsigned DW         = 32;
  localparam int unsigned IN_W       = 5 * DW;
  localparam int unsigned OUT_W      = 10 * DW;
  localparam int unsigned GAMMA_W    = 17;
  localparam int unsigned GAMMA_FRAC = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 17'd26214;

  // Divider: one overflow check stage, then one quotient bit per stage.
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned DIV_LAT    = QUO_W + 1;
  // Back-end register stages up to and including the output register.
  localparam int unsigned PIPE_DEPTH = 2 * DIV_LAT + 9;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_DENSITY = 2'd1,
    STATUS_SATURATED   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DW-1:0] density;
    logic signed [DW-1:0] mom_x;
    logic signed [DW-1:0] mom_y;
    logic signed [DW-1:0] mom_z;
    logic signed [DW-1:0] energy;
    logic                 nonpos;
  } item_t;

  typedef struct packed {
    logic                 nonpos;
    logic signed [DW-1:0] mom_x;
    logic signed [DW-1:0] mom_y;
    logic signed [DW-1:0] energy;
  } aux_t;

  typedef struct packed {
    logic                 nonpos;
    logic                 sat;
    logic signed [DW-1:0] mom_x;
    logic signed [DW-1:0] mom_y;
    logic signed [DW-1:0] energy;
    logic signed [DW+1:0] q_xx;
    logic signed [DW+1:0] q_yy;
    logic signed [DW+1:0] q_xy;
    logic signed [DW+1:0] q_xz;
    logic signed [DW+1:0] q_yz;
    logic signed [DW-1:0] p;
    logic signed [DW-1:0] h;
  } mid_t;

  // A quotient magnitude at or above 2^32 is held at 2^32: every later use
  // saturates the same way as with the exact value.
  function automatic logic signed [DW+1:0] div_val(logic [QUO_W-1:0] q, logic ovf,
                                                   logic neg);
    logic [DW+1:0] mag;
    mag = ovf ? {2'b01, {QUO_W{1'b0}}} : {2'b00, q};
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic over64(logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [DW-1:0] clamp64(logic signed [63:0] v);
    logic signed [DW-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

endpackage

### hdl/efx_front.sv
module efx_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [efx_pkg::IN_W-1:0]   data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output efx_pkg::item_t             item_o
);
  import efx_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Unpack the beat and flag a density that is zero or negative.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q.density <= data_i[DW-1:0];
      item_q.mom_x   <= data_i[2*DW-1:DW];
      item_q.mom_y   <= data_i[3*DW-1:2*DW];
      item_q.mom_z   <= data_i[4*DW-1:3*DW];
      item_q.energy  <= data_i[5*DW-1:4*DW];
      item_q.nonpos  <= data_i[DW-1] || (data_i[DW-1:0] == '0);
    end
  end

endmodule

### hdl/efx_fifo.sv
module efx_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  efx_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output efx_pkg::item_t pop_item_o
);
  import efx_pkg::*;

  item_t      mem_q [FIFO_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

### hdl/efx_div.sv
module efx_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [63:0]               num_i,
  input  logic [32:0]               den_i,
  input  logic                      neg_i,
  output logic [efx_pkg::QUO_W-1:0] q_o,
  output logic                      ovf_o,
  output logic                      neg_o
);
  import efx_pkg::*;

  logic [63:0]      rem_q [QUO_W];
  logic [32:0]      den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic             ovf_q [DIV_LAT];
  logic             neg_q [DIV_LAT];

  // The first stage only decides whether the quotient reaches 2^32.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= {1'b0, num_i} >= {den_i, 32'b0};
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
    localparam int unsigned B = DIV_LAT - 1 - k;
    logic [64:0] sh;
    logic        take;

    assign sh   = {32'b0, den_q[k-1]} << B;
    assign take = {1'b0, rem_q[k-1]} >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_q[k-1] | (QUO_W'(take) << B);
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end

    if (k < QUO_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? rem_q[k-1] - sh[63:0] : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign q_o   = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];
  assign neg_o = neg_q[DIV_LAT-1];

endmodule

### hdl/efx_back.sv
module efx_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [efx_pkg::GAMMA_W-1:0] gamma_i,
  input  logic                        in_valid_i,
  input  efx_pkg::item_t              in_item_i,
  output logic                        in_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [efx_pkg::OUT_W-1:0]   flux_o,
  output logic [1:0]                  status_o
);
  import efx_pkg::*;

  logic                  en;
  logic [PIPE_DEPTH:1]   vsh_q;

  // The whole pipeline moves while the output register is free or drained.
  assign en          = !vsh_q[PIPE_DEPTH] || out_ready_i;
  assign in_pop_o    = en && in_valid_i;
  assign out_valid_o = vsh_q[PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsh_q <= '0;
    end else if (en) begin
      vsh_q <= {vsh_q[PIPE_DEPTH-1:1], in_valid_i};
    end
  end

  // Stage 1: products of the momenta.
  logic signed [63:0] mxx_q, myy_q, mxy_q, mxz_q, myz_q;
  logic signed [DW-1:0] rho1_q;
  aux_t aux1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mxx_q  <= 64'(in_item_i.mom_x) * 64'(in_item_i.mom_x);
      myy_q  <= 64'(in_item_i.mom_y) * 64'(in_item_i.mom_y);
      mxy_q  <= 64'(in_item_i.mom_x) * 64'(in_item_i.mom_y);
      mxz_q  <= 64'(in_item_i.mom_x) * 64'(in_item_i.mom_z);
      myz_q  <= 64'(in_item_i.mom_y) * 64'(in_item_i.mom_z);
      rho1_q <= in_item_i.density;
      aux1_q <= '{nonpos: in_item_i.nonpos, mom_x: in_item_i.mom_x,
                  mom_y: in_item_i.mom_y, energy: in_item_i.energy};
    end
  end

  // Stage 2: divider operands as magnitude and sign.
  logic [63:0] ssum_q, axx_q, ayy_q, axy_q, axz_q, ayz_q;
  logic        nxy_q, nxz_q, nyz_q;
  logic [32:0] den_q, den2_q;
  aux_t        aux2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssum_q <= 64'(mxx_q) + 64'(myy_q);
      axx_q  <= 64'(mxx_q);
      ayy_q  <= 64'(myy_q);
      axy_q  <= abs64(mxy_q);
      axz_q  <= abs64(mxz_q);
      ayz_q  <= abs64(myz_q);
      nxy_q  <= mxy_q[63];
      nxz_q  <= mxz_q[63];
      nyz_q  <= myz_q[63];
      den_q  <= {1'b0, rho1_q};
      den2_q <= {rho1_q, 1'b0};
      aux2_q <= aux1_q;
    end
  end

  logic [QUO_W-1:0] q_ke, q_xx, q_yy, q_xy, q_xz, q_yz, q_xe, q_ye;
  logic o_ke, o_xx, o_yy, o_xy, o_xz, o_yz, o_xe, o_ye;
  logic s_ke, s_xx, s_yy, s_xy, s_xz, s_yz, s_xe, s_ye;

  efx_div u_div_ke (.clk_i, .en_i(en), .num_i(ssum_q), .den_i(den2_q), .neg_i(1'b0),
                    .q_o(q_ke), .ovf_o(o_ke), .neg_o(s_ke));
  efx_div u_div_xx (.clk_i, .en_i(en), .num_i(axx_q), .den_i(den_q), .neg_i(1'b0),
                    .q_o(q_xx), .ovf_o(o_xx), .neg_o(s_xx));
  efx_div u_div_yy (.clk_i, .en_i(en), .num_i(ayy_q), .den_i(den_q), .neg_i(1'b0),
                    .q_o(q_yy), .ovf_o(o_yy), .neg_o(s_yy));
  efx_div u_div_xy (.clk_i, .en_i(en), .num_i(axy_q), .den_i(den_q), .neg_i(nxy_q),
                    .q_o(q_xy), .ovf_o(o_xy), .neg_o(s_xy));
  efx_div u_div_xz (.clk_i, .en_i(en), .num_i(axz_q), .den_i(den_q), .neg_i(nxz_q),
                    .q_o(q_xz), .ovf_o(o_xz), .neg_o(s_xz));
  efx_div u_div_yz (.clk_i, .en_i(en), .num_i(ayz_q), .den_i(den_q), .neg_i(nyz_q),
                    .q_o(q_yz), .ovf_o(o_yz), .neg_o(s_yz));

  aux_t adl_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      adl_q[0] <= aux2_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        adl_q[k] <= adl_q[k-1];
      end
    end
  end

  // Stage 36: kinetic energy (never negative), E - ke.
  aux_t                aux35;
  logic                ke_sat;
  logic [DW-1:0]       ke;
  mid_t                mid36_q, mid37_q, mid38_q, mid39_q, mid40_q, mid41_q;
  mid_t                mid38_d, mid39_d;
  logic signed [DW:0]  diff_q;

  assign aux35  = adl_q[DIV_LAT-1];
  assign ke_sat = o_ke || q_ke[QUO_W-1] || s_ke;
  assign ke     = ke_sat ? 32'h7fff_ffff : q_ke;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q  <= {aux35.energy[DW-1], aux35.energy} - $signed({1'b0, ke});
      mid36_q <= '{nonpos: aux35.nonpos, sat: ke_sat, mom_x: aux35.mom_x,
                   mom_y: aux35.mom_y, energy: aux35.energy,
                   q_xx: div_val(q_xx, o_xx, s_xx), q_yy: div_val(q_yy, o_yy, s_yy),
                   q_xy: div_val(q_xy, o_xy, s_xy), q_xz: div_val(q_xz, o_xz, s_xz),
                   q_yz: div_val(q_yz, o_yz, s_yz), p: '0, h: '0};
    end
  end

  // Stage 37: (gamma - 1) * (E - ke).
  logic signed [50:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= 51'($signed({1'b0, gamma_i})) * 51'(diff_q);
      mid37_q <= mid36_q;
    end
  end

  // Stage 38: pressure; the arithmetic shift rounds toward minus infinity.
  logic signed [50:0] pw;

  assign pw = prod_q >>> GAMMA_FRAC;

  always_comb begin
    mid38_d     = mid37_q;
    mid38_d.p   = clamp64(64'(pw));
    mid38_d.sat = mid37_q.sat || over64(64'(pw));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid38_q <= mid38_d;
    end
  end

  // Stage 39: enthalpy term E + p.
  logic signed [63:0] hs;

  assign hs = 64'(mid38_q.energy) + 64'(mid38_q.p);

  always_comb begin
    mid39_d     = mid38_q;
    mid39_d.h   = clamp64(hs);
    mid39_d.sat = mid38_q.sat || over64(hs);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid39_q <= mid39_d;
    end
  end

  // Stage 40 and 41: momentum times enthalpy, then magnitude and sign.
  logic signed [63:0] mxh_q, myh_q;
  logic [63:0]        axe_q, aye_q;
  logic               nxe_q, nye_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mxh_q   <= 64'(mid39_q.mom_x) * 64'(mid39_q.h);
      myh_q   <= 64'(mid39_q.mom_y) * 64'(mid39_q.h);
      mid40_q <= mid39_q;
      axe_q   <= abs64(mxh_q);
      aye_q   <= abs64(myh_q);
      nxe_q   <= mxh_q[63];
      nye_q   <= myh_q[63];
      mid41_q <= mid40_q;
    end
  end

  // Density is delayed separately; the last tap lines up with stage 41.
  logic [32:0] rdl_q [DIV_LAT];
  logic [32:0] rhol_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rdl_q[0] <= den_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        rdl_q[k] <= rdl_q[k-1];
      end
      rhol_q[0] <= rdl_q[DIV_LAT-1];
      for (int k = 1; k < 6; k++) begin
        rhol_q[k] <= rhol_q[k-1];
      end
    end
  end

  efx_div u_div_xe (.clk_i, .en_i(en), .num_i(axe_q), .den_i(rhol_q[5]),
                    .neg_i(nxe_q), .q_o(q_xe), .ovf_o(o_xe), .neg_o(s_xe));
  efx_div u_div_ye (.clk_i, .en_i(en), .num_i(aye_q), .den_i(rhol_q[5]),
                    .neg_i(nye_q), .q_o(q_ye), .ovf_o(o_ye), .neg_o(s_ye));

  mid_t mdl_q [DIV_LAT];
  mid_t mf;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mdl_q[0] <= mid41_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        mdl_q[k] <= mdl_q[k-1];
      end
    end
  end

  assign mf = mdl_q[DIV_LAT-1];

  // Output register: sums with pressure, saturation and status.
  logic signed [63:0] f_xx, f_yy, f_xy, f_xz, f_yz, f_xe, f_ye;
  logic               sat_f;
  logic [OUT_W-1:0]   flux_d, flux_q;
  status_e            status_d, status_q;

  always_comb begin
    f_xx  = 64'(mf.q_xx) + 64'(mf.p);
    f_yy  = 64'(mf.q_yy) + 64'(mf.p);
    f_xy  = 64'(mf.q_xy);
    f_xz  = 64'(mf.q_xz);
    f_yz  = 64'(mf.q_yz);
    f_xe  = 64'(div_val(q_xe, o_xe, s_xe));
    f_ye  = 64'(div_val(q_ye, o_ye, s_ye));
    sat_f = mf.sat || over64(f_xx) || over64(f_yy) || over64(f_xy) || over64(f_xz)
            || over64(f_yz) || over64(f_xe) || over64(f_ye);
    flux_d = {clamp64(f_ye), clamp64(f_yz), clamp64(f_yy), clamp64(f_xy), mf.mom_y,
              clamp64(f_xe), clamp64(f_xz), clamp64(f_xy), clamp64(f_xx), mf.mom_x};
    if (mf.nonpos) begin
      flux_d   = '0;
      status_d = STATUS_BAD_DENSITY;
    end else if (sat_f) begin
      status_d = STATUS_SATURATED;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flux_q   <= flux_d;
      status_q <= status_d;
    end
  end

  assign flux_o   = flux_q;
  assign status_o = status_q;

endmodule

### hdl/euler_flux_2d.sv
// Two-dimensional Euler flux of one conserved cell state per beat.
// Input stream (s_axis): one beat carries density, x, y and z momentum and
// total energy, all signed Q16.16. Output stream (m_axis): one beat carries
// the five x-direction and five y-direction flux components in Q16.16 and a
// status code in tuser (ok, density not positive, saturated).
// gamma_minus_one must be written through cfg_we_i/cfg_wdata_i while the block
// is idle; the block does not enforce this. It is unsigned with 16 fraction bits.
// A beat is accepted every cycle when the output side keeps up. A result is
// offered once its beat has passed the input register, queue and back pipeline.
// The back pipeline holds two chained 33-stage dividers (kinetic energy, then
// the energy flux), one quotient bit per stage, plus the pressure stages.
// While a result waits on a low m_axis_tready the whole back pipeline holds;
// the two-entry queue and the input register keep taking beats until they are full.
// Reset clears all valid state and loads gamma_minus_one with 0.4; no
// result is in flight afterwards.
module euler_flux_2d (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efx_pkg::GAMMA_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // density, momentum_x, momentum_y, momentum_z, total_energy
  input  logic [efx_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // x_mass_flux, x_xmom_flux, x_ymom_flux, x_zmom_flux, x_energy_flux,
  // y_mass_flux, y_xmom_flux, y_ymom_flux, y_zmom_flux, y_energy_flux
  output logic [efx_pkg::OUT_W-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                  m_axis_tuser
);
  import efx_pkg::*;

  logic [GAMMA_W-1:0] gamma_q;
  logic               fr_valid, fr_ready;
  item_t              fr_item;
  logic               q_valid, q_pop;
  item_t              q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RESET;
    end else if (cfg_we_i) begin
      gamma_q <= cfg_wdata_i;
    end
  end

  efx_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .data_i(s_axis_tdata),
    .valid_o(fr_valid), .ready_i(fr_ready), .item_o(fr_item)
  );

  efx_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(fr_valid), .push_ready_o(fr_ready), .push_item_i(fr_item),
    .pop_valid_o(q_valid), .pop_i(q_pop), .pop_item_o(q_item)
  );

  efx_back u_back (
    .clk_i, .rst_ni, .gamma_i(gamma_q),
    .in_valid_i(q_valid), .in_item_i(q_item), .in_pop_o(q_pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .flux_o(m_axis_tdata), .status_o(m_axis_tuser)
  );

endmodule

### hdl/efx_checker.sv
`include "euler_flux_2d_defines.svh"

module efx_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [efx_pkg::OUT_W-1:0] m_axis_tdata,
  input logic [1:0]                m_axis_tuser
);
  import efx_pkg::*;

  // A bad density must come with all fluxes cleared.
  `EFX_ASSERT_SAME(a_bad_density_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == STATUS_BAD_DENSITY), m_axis_tdata == '0, "flux not zero for bad density")

  // The two cross momentum fluxes are the same quantity.
  `EFX_ASSERT_SAME(a_cross_flux, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[95:64] == m_axis_tdata[223:192], "cross momentum fluxes differ")

  `EFX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind euler_flux_2d efx_checker u_efx_checker (.*);
